[rtl/ehef_pkg.sv]
// Package for the evicting event history store.
// Holds shared constants, register addresses and the sequencer state type.
// Used by every module under rtl/.
package ehef_pkg;

    // Default geometry
    localparam int DEF_DEPTH       = 64;
    localparam int DEF_HANDLE_BITS = 16;
    localparam int DEF_TIME_BITS   = 32;

    // Age arithmetic is done on the low 32 bits of the timestamps
    localparam int AGE_BITS = 32;

    // Minimum number of evictions once the limit is exceeded
    localparam int MIN_EVICT = 10;
    localparam int EV_BITS   = $clog2(MIN_EVICT + 1);

    // Register file
    localparam int CFG_ADDR_BITS  = 3;
    localparam int MAX_ENT_BITS   = 6;
    localparam int WINDOW_BITS    = 31;
    localparam logic [MAX_ENT_BITS-1:0] MAX_ENT_RST = 6'd63;
    localparam logic [WINDOW_BITS-1:0]  WINDOW_RST  = 31'd0;

    // Register index, taken from paddr[2]
    localparam logic REG_MAX_ENTRIES = 1'b0;
    localparam logic REG_WINDOW      = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } ehef_state_t;

endpackage

[rtl/ehef_store.sv]
// Entry store: one write port, one read port with registered read data.
// Holds handle and timestamp of each entry side by side. Uses ehef_pkg.
module ehef_store
    import ehef_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH,
    parameter int WIDTH = DEF_HANDLE_BITS + DEF_TIME_BITS
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ehef_age_unit.sv]
// Shared age compare unit: decides whether the oldest entry is evicted.
// One 32-bit subtract and compare, reused for every entry. Uses ehef_pkg.
module ehef_age_unit
    import ehef_pkg::*;
(
    input  logic [AGE_BITS-1:0]    now_time,
    input  logic [AGE_BITS-1:0]    old_time,
    input  logic [WINDOW_BITS-1:0] window,
    input  logic                   below_min,
    input  logic                   nonempty,
    output logic                   evict
);

    logic [AGE_BITS-1:0] age;
    logic                beyond;

    // Signed age: a set sign bit never counts as old
    assign age    = now_time - old_time;
    assign beyond = !age[AGE_BITS-1] && (age[AGE_BITS-2:0] > window);
    assign evict  = nonempty && (below_min || beyond);

endmodule

[rtl/event_history_evicting_fifo_top.sv]
// Evicting event history store, top level.
// Uses ehef_pkg, ehef_store and ehef_age_unit.
//
// Usage:
//   s_ channel: one item per event, tdata = {event_time, event_handle}.
//   m_ channel: one item per evicted entry, oldest first,
//     tdata = {evicted_time, evicted_handle}, tlast marks the final
//     eviction caused by one insert. Most inserts evict nothing.
//   APB port: register 0 max_entries at 0x0, register 1 retention_window
//     at 0x4; write only while the block is idle.
// Operation:
//   An insert that evicts nothing leaves s_tready high. An insert that
//   evicts entries holds s_tready low until its run ends: each entry is
//   read from the store in the read step and checked by the shared age
//   compare unit in the check step that follows. The last result
//   leaves through the output register while the next item is taken.
// Reset: synchronous, active low; the store is empty, max_entries = 63,
//   retention_window = 0. Store contents need no clearing.
// Stall: when m_tready is low the sequencer waits in its check step and
//   the output register holds its item.
module event_history_evicting_fifo_top
    import ehef_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS,
    localparam int OUT_TIME_BITS = (TIME_BITS < AGE_BITS) ? TIME_BITS : AGE_BITS,
    localparam int S_TDATA_W = ((HANDLE_BITS + TIME_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((HANDLE_BITS + OUT_TIME_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input items
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_W-1:0]     s_tdata,   // event_handle, event_time
    // Result items
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_W-1:0]     m_tdata,   // evicted_handle, evicted_time
    output logic                     m_tlast,   // last_of_run
    // Configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = HANDLE_BITS + TIME_BITS;

    // Registers
    ehef_state_t              state_reg, state_next;
    logic [PW-1:0]            newest_reg, newest_next;
    logic [PW-1:0]            oldest_reg, oldest_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [EV_BITS-1:0]       ev_reg, ev_next;
    logic [AGE_BITS-1:0]      now_reg, now_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [HANDLE_BITS-1:0]   pend_handle_reg, pend_handle_next;
    logic [OUT_TIME_BITS-1:0] pend_time_reg, pend_time_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_last_reg, m_last_next;
    logic [HANDLE_BITS-1:0]   m_handle_reg, m_handle_next;
    logic [OUT_TIME_BITS-1:0] m_time_reg, m_time_next;
    logic [MAX_ENT_BITS-1:0]  max_ent_reg;
    logic [WINDOW_BITS-1:0]   window_reg;

    // Datapath
    logic [HANDLE_BITS-1:0]  in_handle;
    logic [TIME_BITS-1:0]    in_time;
    logic [63:0]             in_time_ext;
    logic [63:0]             rd_time_ext;
    logic [AGE_BITS-1:0]     old_time32;
    logic                    s_fire;
    logic                    cfg_wr;
    logic [PW-1:0]           slot;
    logic [MAX_ENT_BITS-1:0] limit;
    logic [6:0]              count_inc;
    logic                    wr_en, rd_en;
    logic [EW-1:0]           rd_data;
    logic [HANDLE_BITS-1:0]  rd_handle;
    logic [TIME_BITS-1:0]    rd_time;
    logic                    evict;
    logic                    out_busy;

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] pos);
        return (pos == PW'(DEPTH - 1)) ? '0 : pos + PW'(1);
    endfunction

    // Input unpacking
    assign in_handle   = s_tdata[HANDLE_BITS-1:0];
    assign in_time     = s_tdata[HANDLE_BITS +: TIME_BITS];
    assign in_time_ext = 64'(in_time);
    assign s_fire      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_IDLE);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_ent_reg <= MAX_ENT_RST;
            window_reg  <= WINDOW_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MAX_ENTRIES: max_ent_reg <= pwdata[MAX_ENT_BITS-1:0];
                REG_WINDOW:      window_reg  <= pwdata[WINDOW_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_ENTRIES: prdata = 32'(max_ent_reg);
            REG_WINDOW:      prdata = 32'(window_reg);
            default:         prdata = '0;
        endcase
    end

    // Effective limit, capped at DEPTH-1
    assign limit = (max_ent_reg > MAX_ENT_BITS'(DEPTH - 1)) ?
                   MAX_ENT_BITS'(DEPTH - 1) : max_ent_reg;
    assign count_inc = 7'(count_reg) + 7'd1;
    assign slot      = next_pos(newest_reg);

    // Entry store
    assign wr_en = s_fire;

    ehef_store #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data ({in_time, in_handle}),
        .rd_en   (rd_en),
        .rd_addr (oldest_reg),
        .rd_data (rd_data)
    );

    assign rd_handle   = rd_data[HANDLE_BITS-1:0];
    assign rd_time     = rd_data[HANDLE_BITS +: TIME_BITS];
    assign rd_time_ext = 64'(rd_time);
    assign old_time32  = rd_time_ext[AGE_BITS-1:0];

    // Shared age compare unit
    ehef_age_unit u_age (
        .now_time  (now_reg),
        .old_time  (old_time32),
        .window    (window_reg),
        .below_min (ev_reg < EV_BITS'(MIN_EVICT)),
        .nonempty  (count_reg != '0),
        .evict     (evict)
    );

    assign out_busy = m_valid_reg && !m_tready;

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            newest_reg     <= '0;
            oldest_reg     <= '0;
            count_reg      <= '0;
            ev_reg         <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            newest_reg     <= newest_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            ev_reg         <= ev_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        now_reg         <= now_next;
        pend_handle_reg <= pend_handle_next;
        pend_time_reg   <= pend_time_next;
        m_last_reg      <= m_last_next;
        m_handle_reg    <= m_handle_next;
        m_time_reg      <= m_time_next;
    end

    // Next state and datapath control
    always_comb begin
        state_next       = state_reg;
        newest_next      = newest_reg;
        oldest_next      = oldest_reg;
        count_next       = count_reg;
        ev_next          = ev_reg;
        now_next         = now_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        pend_time_next   = pend_time_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_last_next      = m_last_reg;
        m_handle_next    = m_handle_reg;
        m_time_next      = m_time_reg;
        rd_en            = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    newest_next = slot;
                    now_next    = in_time_ext[AGE_BITS-1:0];
                    if (count_reg == '0) begin
                        // Empty store: new entry is the only one
                        oldest_next = slot;
                        count_next  = CW'(1);
                    end else begin
                        count_next = CW'(count_inc);
                        if (count_inc > 7'(limit)) begin
                            ev_next         = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                // Fetch the oldest entry
                rd_en      = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // The check on this entry settles tlast of the pending one
                if (!pend_valid_reg || !out_busy) begin
                    if (pend_valid_reg) begin
                        m_valid_next  = 1'b1;
                        m_last_next   = !evict;
                        m_handle_next = pend_handle_reg;
                        m_time_next   = pend_time_reg;
                    end
                    if (evict) begin
                        pend_valid_next  = 1'b1;
                        pend_handle_next = rd_handle;
                        pend_time_next   = old_time32[OUT_TIME_BITS-1:0];
                        oldest_next      = next_pos(oldest_reg);
                        count_next       = count_reg - CW'(1);
                        if (ev_reg < EV_BITS'(MIN_EVICT)) begin
                            ev_next = ev_reg + EV_BITS'(1);
                        end
                        state_next = ST_READ;
                    end else begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output packing
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_TDATA_W'({m_time_reg, m_handle_reg});

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds store depth");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending eviction left behind in idle");

    a_run_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && state_next == ST_IDLE && pend_valid_reg)
        |-> (ev_reg == EV_BITS'(MIN_EVICT) || count_reg == '0))
        else $error("eviction run ended before the minimum");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_handle_reg)
        && $stable(m_time_reg) && $stable(m_last_reg)))
        else $error("result item changed while stalled");

endmodule

[dv/event_history_evicting_fifo_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the evicting event history store top level.
// Needs ehef_pkg and event_history_evicting_fifo_top from rtl/, with the store and age unit that the top uses.
module event_history_evicting_fifo_top_tb;
    import ehef_pkg::*;

    localparam int HIST_DEPTH = DEF_DEPTH;

    // One evicted entry as it should leave the m_ channel
    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] stamp;
        logic        last;
    } eviction_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [47:0]              s_tdata = '0;   // event_handle, event_time
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [47:0]              m_tdata;        // evicted_handle, evicted_time
    logic                     m_tlast;        // last_of_run
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    // Shadow copy of the history ring and the registers
    logic [15:0]              hist_handle [HIST_DEPTH];
    logic [31:0]              hist_stamp  [HIST_DEPTH];
    logic [5:0]               hist_newest = '0;
    logic [5:0]               hist_oldest = '0;
    int                       hist_count  = 0;
    logic [MAX_ENT_BITS-1:0]  limit_q  = MAX_ENT_RST;
    logic [WINDOW_BITS-1:0]   window_q = WINDOW_RST;

    eviction_t                pending_evictions [$];
    int                       error_count   = 0;
    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    logic [31:0]              stamp_base    = '0;

    event_history_evicting_fifo_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("event_history_evicting_fifo_top_tb NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Insert one event into the shadow ring and queue the evictions it causes
    function automatic void record_event(logic [15:0] handle, logic [31:0] stamp);
        logic [31:0] age;
        int          removed;
        eviction_t   ev;
        hist_newest = hist_newest + 6'd1;
        hist_handle[hist_newest] = handle;
        hist_stamp[hist_newest]  = stamp;
        if (hist_count == 0) begin
            hist_oldest = hist_newest;
            hist_count  = 1;
            return;
        end
        hist_count++;
        if (hist_count <= int'(limit_q))
            return;
        removed = 0;
        while (hist_count > 0) begin
            age = stamp - hist_stamp[hist_oldest];
            // past the minimum, only strictly positive ages beyond the window go
            if (removed >= MIN_EVICT && (age[31] || age <= {1'b0, window_q}))
                break;
            ev.handle = hist_handle[hist_oldest];
            ev.stamp  = hist_stamp[hist_oldest];
            ev.last   = 1'b0;
            pending_evictions.push_back(ev);
            hist_oldest = hist_oldest + 6'd1;
            hist_count--;
            removed++;
        end
        if (removed > 0)
            pending_evictions[pending_evictions.size()-1].last = 1'b1;
    endfunction

    // Random stall on the result side, and compare every accepted item
    always @(posedge aclk) begin : eviction_check
        eviction_t want;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_evictions.size() == 0) begin
                report_mismatch("eviction with none expected", m_tdata[47:16],
                                32'd0);
            end else begin
                want = pending_evictions.pop_front();
                if (m_tdata[15:0] !== want.handle)
                    report_mismatch("evicted_handle", {16'd0, m_tdata[15:0]},
                                    {16'd0, want.handle});
                if (m_tdata[47:16] !== want.stamp)
                    report_mismatch("evicted_time", m_tdata[47:16], want.stamp);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", {31'd0, m_tlast},
                                    {31'd0, want.last});
            end
        end
    end

    // Offer one event, with random idle cycles first; tvalid stays high after
    task automatic send_event(input logic [15:0] handle, input logic [31:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, handle};
        do @(posedge aclk); while (!s_tready);
        record_event(handle, stamp);
    endtask

    // Stop sending, wait for all evictions, then let the sequencer settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_evictions.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_sel == REG_MAX_ENTRIES)
            limit_q = value[MAX_ENT_BITS-1:0];
        else
            window_q = value[WINDOW_BITS-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check(input logic reg_sel);
        logic [31:0] want;
        want = (reg_sel == REG_MAX_ENTRIES) ? {26'd0, limit_q} : {1'b0, window_q};
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            report_mismatch("register read", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Timestamps mostly creep forward; some steps go back, wrap or jump by half range
    function automatic logic [31:0] next_stamp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            stamp_base = stamp_base + $urandom_range(0, 12);
        else if (pick < 88)
            stamp_base = stamp_base - $urandom_range(1, 30);
        else if (pick < 94)
            stamp_base = $urandom;
        else
            stamp_base = stamp_base + 32'h8000_0000 + $urandom_range(0, 8);
        return stamp_base;
    endfunction

    task automatic test_register_defaults();
        cfg_check(REG_MAX_ENTRIES);
        cfg_check(REG_WINDOW);
    endtask

    // Limit 0: first insert into an empty store is kept, the next empties it
    task automatic test_empty_store_insert();
        cfg_write(REG_MAX_ENTRIES, 32'd0);
        cfg_write(REG_WINDOW, 32'd0);
        send_event(16'hFFFF, 32'hFFFF_FFFF);
        send_event(16'h0000, 32'h0000_0000);
        wait_idle();
    endtask

    // Ten forced evictions, one more beyond the window, then a negative age stops it
    task automatic test_window_eviction();
        cfg_write(REG_MAX_ENTRIES, 32'd12);
        cfg_write(REG_WINDOW, 32'd5);
        cfg_check(REG_MAX_ENTRIES);
        cfg_check(REG_WINDOW);
        for (int i = 0; i < 10; i++)
            send_event((i == 0) ? 16'h0000 : 16'hFFFF - 16'(i), 32'd1000 + 32'(i));
        send_event(16'hA5A5, 32'd1090);
        send_event(16'h5A5A, 32'd1100 + 32'h8000_0000);
        send_event(16'hFFFF, 32'd1100);
        wait_idle();
    endtask

    // Lowering the limit below the count empties the store on the next insert;
    // upper pwdata bits must be dropped
    task automatic test_lowered_limit();
        cfg_write(REG_MAX_ENTRIES, 32'hFFFF_FFC0);
        cfg_write(REG_WINDOW, 32'hFFFF_FFFF);
        cfg_check(REG_MAX_ENTRIES);
        cfg_check(REG_WINDOW);
        send_event(16'h1234, 32'h7FFF_FFFF);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int          limit_plan [9] = '{63, 0, 11, -1, 20, 63, 1, -1, 10};
        logic [31:0] limit_val;
        logic [31:0] window_val;
        stamp_base = $urandom;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 25 : 0;
            for (int seg = 0; seg < 3; seg++) begin
                limit_val = (limit_plan[phase*3+seg] < 0) ? $urandom_range(0, 63)
                                                          : limit_plan[phase*3+seg];
                case ($urandom_range(4))
                    0: window_val = 32'd0;
                    1: window_val = $urandom_range(1, 40);
                    2: window_val = $urandom_range(41, 1000);
                    3: window_val = 32'hFFFF_FFFF;
                    default: window_val = $urandom;
                endcase
                // junk above the register widths
                cfg_write(REG_MAX_ENTRIES, {1'($urandom_range(0, 1)), 31'd0} | limit_val);
                cfg_write(REG_WINDOW, window_val);
                for (int n = 0; n < 41; n++)
                    send_event(16'($urandom), next_stamp());
                wait_idle();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 25;
        recv_idle_pct = 61;
        test_register_defaults();
        test_empty_store_insert();
        test_window_eviction();
        test_lowered_limit();
        test_random_traffic();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("event_history_evicting_fifo_top_tb OK");
        end else begin
            $display("event_history_evicting_fifo_top_tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/ehef_pkg.sv
rtl/ehef_store.sv
rtl/ehef_age_unit.sv
rtl/event_history_evicting_fifo_top.sv
dv/event_history_evicting_fifo_top_tb.sv
